FILE: hw/rtl/thn_pkg.sv
// ============================================================================
// thn_pkg
// Shared types and constants for the toroidal halfedge navigator.
// ============================================================================
package thn_pkg;

  // Field widths.
  localparam int HE_W   = 23;  // halfedge index
  localparam int CELL_W = 21;  // cell number (halfedge / 6)
  localparam int DIM_W  = 11;  // grid dimension registers
  localparam int LOC_W  = 3;   // local halfedge number 0..5
  localparam int AREA_W = 2 * DIM_W;

  // Reciprocal of six for exact division of any HE_W-bit index.
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_SIX = 24'd11184811;

  // Configuration register indexes.
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // Local halfedge numbers that leave the cell.
  localparam logic [LOC_W-1:0] LOC_EAST  = 3'd0;
  localparam logic [LOC_W-1:0] LOC_NORTH = 3'd1;
  localparam logic [LOC_W-1:0] LOC_WEST  = 3'd3;
  localparam logic [LOC_W-1:0] LOC_SOUTH = 3'd4;

  // Query kinds.
  typedef enum logic [1:0] {
    ACT_OPPOSITE = 2'd0,
    ACT_NEXT     = 2'd1,
    ACT_PREV     = 2'd2,
    ACT_EDGE     = 2'd3
  } action_t;

  // Item context that travels beside the divider.
  typedef struct packed {
    logic [HE_W-1:0]  simple_idx;  // result for next, prev and edge
    action_t          act;
    logic [LOC_W-1:0] loc;
    logic             bad;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } thn_ctx_t;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    thn_ctx_t          ctx;
    logic [CELL_W-1:0] dvd;  // dividend bits not yet brought down
    logic [CELL_W-1:0] quo;  // quotient bits so far (row)
    logic [DIM_W-1:0]  rem;  // partial remainder (column)
  } thn_div_t;

endpackage

FILE: hw/rtl/thn_front.sv
// ============================================================================
// thn_front
// Input capture, cell and local number extraction, range check and the
// in-triangle results. Three register stages.
// ============================================================================
module thn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  thn_pkg::action_t   in_act,
  input  logic [22:0]        in_he,
  input  logic [10:0]        cols_eff,
  input  logic [10:0]        rows_eff,
  output logic               vld_o,
  output thn_pkg::thn_div_t  dat_o
);
  import thn_pkg::*;

  localparam int PROD_W = HE_W + RECIP_W;

  logic              s0_vld_r;
  logic [HE_W-1:0]   s0_he_r;
  action_t           s0_act_r;
  logic [DIM_W-1:0]  s0_cols_r;
  logic [DIM_W-1:0]  s0_rows_r;

  logic              s1_vld_r;
  logic [HE_W-1:0]   s1_he_r;
  action_t           s1_act_r;
  logic [DIM_W-1:0]  s1_cols_r;
  logic [DIM_W-1:0]  s1_rows_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [AREA_W-1:0] s1_area_r;

  logic              s2_vld_r;
  thn_div_t          s2_dat_r;

  logic [PROD_W-1:0] recip_prod;
  logic [HE_W-1:0]   six_cell;
  logic [HE_W-1:0]   loc_full;
  logic [LOC_W-1:0]  loc;
  logic [1:0]        tri_pos;
  logic [AREA_W+2:0] total;
  logic              bad;
  logic [HE_W-1:0]   simple_idx;
  thn_div_t          s2_dat_nxt;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Divide by six through the reciprocal; grid area for the range check.
  assign recip_prod = {{RECIP_W{1'b0}}, s0_he_r} * {{HE_W{1'b0}}, RECIP_SIX};

  always_ff @(posedge clk) begin
    s0_he_r   <= in_he;
    s0_act_r  <= in_act;
    s0_cols_r <= cols_eff;
    s0_rows_r <= rows_eff;
    s1_he_r   <= s0_he_r;
    s1_act_r  <= s0_act_r;
    s1_cols_r <= s0_cols_r;
    s1_rows_r <= s0_rows_r;
    s1_cell_r <= recip_prod[RECIP_SHIFT +: CELL_W];
    s1_area_r <= s0_rows_r * s0_cols_r;
    s2_dat_r  <= s2_dat_nxt;
  end

  // Local number, range check and the in-triangle results.
  always_comb begin
    six_cell = {s1_cell_r, 2'b00} + {1'b0, s1_cell_r, 1'b0};
    loc_full = s1_he_r - six_cell;
    loc      = loc_full[LOC_W-1:0];
    tri_pos  = (loc >= 3'd3) ? 2'(loc - 3'd3) : loc[1:0];
    total    = {1'b0, s1_area_r, 2'b00} + {2'b00, s1_area_r, 1'b0};
    bad      = ({2'b00, s1_he_r} >= total);
    case (s1_act_r)
      ACT_NEXT: simple_idx = (tri_pos == 2'd2) ? s1_he_r - 23'd2 : s1_he_r + 23'd1;
      ACT_PREV: simple_idx = (tri_pos == 2'd0) ? s1_he_r + 23'd2 : s1_he_r - 23'd1;
      ACT_EDGE: simple_idx = s1_he_r >> 1;
      default:  simple_idx = '0;
    endcase

    s2_dat_nxt                = '0;
    s2_dat_nxt.ctx.simple_idx = simple_idx;
    s2_dat_nxt.ctx.act        = s1_act_r;
    s2_dat_nxt.ctx.loc        = loc;
    s2_dat_nxt.ctx.bad        = bad;
    s2_dat_nxt.ctx.cols       = s1_cols_r;
    s2_dat_nxt.ctx.rows       = s1_rows_r;
    s2_dat_nxt.dvd            = s1_cell_r;
  end

  assign vld_o = s2_vld_r;
  assign dat_o = s2_dat_r;

  // An in-range index always splits into a local number below six.
  a_loc_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !s2_dat_r.ctx.bad |-> s2_dat_r.ctx.loc <= 3'd5)
    else $error("local halfedge number out of range");

endmodule

FILE: hw/rtl/thn_div_cell.sv
// ============================================================================
// thn_div_cell
// One restoring division step: brings down one cell-number bit, compares
// against the column count and registers remainder and quotient bit.
// ============================================================================
module thn_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  thn_pkg::thn_div_t  dat_i,
  output logic               vld_o,
  output thn_pkg::thn_div_t  dat_o
);
  import thn_pkg::*;

  logic             vld_r;
  thn_div_t         dat_r;
  thn_div_t         dat_nxt;
  logic [DIM_W:0]   trial;
  logic [DIM_W:0]   diff;
  logic             fits;

  // Compare the shifted remainder with the divisor and subtract on fit.
  always_comb begin
    trial   = {dat_i.rem, dat_i.dvd[CELL_W-1]};
    diff    = trial - {1'b0, dat_i.ctx.cols};
    fits    = (trial >= {1'b0, dat_i.ctx.cols});
    dat_nxt = dat_i;
    dat_nxt.dvd = {dat_i.dvd[CELL_W-2:0], 1'b0};
    dat_nxt.quo = {dat_i.quo[CELL_W-2:0], fits};
    dat_nxt.rem = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

  // The partial remainder never reaches the divisor.
  a_rem_below_cols: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> dat_r.rem < dat_r.ctx.cols)
    else $error("divider remainder not below column count");

endmodule

FILE: hw/rtl/thn_back.sv
// ============================================================================
// thn_back
// Neighbor step with wrap on both axes, rebuild of the halfedge index and
// final result selection. Three register stages, the last one drives the
// result ports.
// ============================================================================
module thn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  thn_pkg::thn_div_t  dat_i,
  output logic               out_vld,
  output logic [22:0]        out_idx,
  output logic               out_bad
);
  import thn_pkg::*;

  logic [DIM_W-1:0]  row;
  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  cols;
  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  col_dec;
  logic [DIM_W-1:0]  row_inc;
  logic [DIM_W-1:0]  row_dec;
  logic [LOC_W-1:0]  lnew;
  logic [DIM_W-1:0]  nrow;
  logic [DIM_W-1:0]  ncol;

  logic              e1_vld_r;
  thn_ctx_t          e1_ctx_r;
  logic [DIM_W-1:0]  e1_nrow_r;
  logic [DIM_W-1:0]  e1_ncol_r;
  logic [LOC_W-1:0]  e1_lnew_r;

  logic              e2_vld_r;
  thn_ctx_t          e2_ctx_r;
  logic [AREA_W-1:0] e2_base_r;
  logic [DIM_W-1:0]  e2_ncol_r;
  logic [LOC_W-1:0]  e2_lnew_r;

  logic [AREA_W-1:0] cell_idx;
  logic [AREA_W+2:0] opp_full;
  logic [HE_W-1:0]   idx_nxt;

  logic              out_vld_r;
  logic [HE_W-1:0]   out_idx_r;
  logic              out_bad_r;

  // Neighbor cell from the current row and column.
  always_comb begin
    row     = dat_i.quo[DIM_W-1:0];
    col     = dat_i.rem;
    cols    = dat_i.ctx.cols;
    rows    = dat_i.ctx.rows;
    col_inc = (col == cols - 11'd1) ? '0 : col + 11'd1;
    col_dec = (col == '0) ? cols - 11'd1 : col - 11'd1;
    row_inc = (row == rows - 11'd1) ? '0 : row + 11'd1;
    row_dec = (row == '0) ? rows - 11'd1 : row - 11'd1;
    lnew    = (dat_i.ctx.loc < 3'd3) ? dat_i.ctx.loc + 3'd3 : dat_i.ctx.loc - 3'd3;
    nrow    = row;
    ncol    = col;
    case (lnew)
      LOC_EAST: begin
        ncol = col_inc;
      end
      LOC_NORTH: begin
        nrow = row_dec;
        if (!row_dec[0]) begin
          ncol = col_inc;
        end
      end
      LOC_WEST: begin
        ncol = col_dec;
      end
      LOC_SOUTH: begin
        nrow = row_inc;
        if (row_inc[0]) begin
          ncol = col_dec;
        end
      end
      default: begin
        nrow = row;
        ncol = col;
      end
    endcase
  end

  // Rebuild the halfedge index and pick the result.
  always_comb begin
    cell_idx = e2_base_r + {{DIM_W{1'b0}}, e2_ncol_r};
    opp_full = {1'b0, cell_idx, 2'b00} + {2'b00, cell_idx, 1'b0}
             + {{(AREA_W){1'b0}}, e2_lnew_r};
    if (e2_ctx_r.bad) begin
      idx_nxt = '0;
    end else if (e2_ctx_r.act == ACT_OPPOSITE) begin
      idx_nxt = opp_full[HE_W-1:0];
    end else begin
      idx_nxt = e2_ctx_r.simple_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r  <= 1'b0;
      e2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      e1_vld_r  <= vld_i;
      e2_vld_r  <= e1_vld_r;
      out_vld_r <= e2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_ctx_r  <= dat_i.ctx;
    e1_nrow_r <= nrow;
    e1_ncol_r <= ncol;
    e1_lnew_r <= lnew;
    e2_ctx_r  <= e1_ctx_r;
    e2_base_r <= e1_nrow_r * e1_ctx_r.cols;
    e2_ncol_r <= e1_ncol_r;
    e2_lnew_r <= e1_lnew_r;
    out_idx_r <= idx_nxt;
    out_bad_r <= e2_ctx_r.bad;
  end

  assign out_vld = out_vld_r;
  assign out_idx = out_idx_r;
  assign out_bad = out_bad_r;

  // For an in-range item the neighbor stays inside the grid.
  a_neighbor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    e1_vld_r && !e1_ctx_r.bad |->
      (e1_nrow_r < e1_ctx_r.rows) && (e1_ncol_r < e1_ctx_r.cols))
    else $error("neighbor cell outside the grid");

endmodule

FILE: hw/rtl/toroidal_halfedge_navigator.sv
// ============================================================================
// toroidal_halfedge_navigator
// Navigation queries on a wrapping grid of six-halfedge cells: opposite,
// next, previous and edge of a halfedge, with an out-of-range flag.
// ============================================================================
//
//  Channel   Ports                                      Handshake
//  --------  -----------------------------------------  ---------------------
//  input     in_action, in_halfedge_in                  start high, busy low
//  result    out_index_out, out_bad_index               out_valid, one cycle
//  config    cfg_index, cfg_wdata                       cfg_we
//
//  One item is taken every cycle; busy never rises.
//  Each result passes through 27 register stages: three front stages, one per
//  row-quotient bit in the 21-cell divider chain, three back stages.
//  Synchronous active-low reset empties the pipeline; the grid size resets
//  to one by one.
//  The receiver cannot stall; results leave in item order.
//
module toroidal_halfedge_navigator #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  thn_pkg::action_t          in_action,
  input  logic [22:0]               in_halfedge_in,
  output logic                      out_valid,
  output logic [22:0]               out_index_out,
  output logic                      out_bad_index,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [10:0]               cfg_wdata
);
  import thn_pkg::*;

  localparam int LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] MaxColsC = LIMIT_W'(MAX_COLS);
  localparam logic [LIMIT_W-1:0] MaxRowsC = LIMIT_W'(MAX_ROWS);
  localparam int LATENCY = CELL_W + 6;

  logic [DIM_W-1:0] grid_cols_r;
  logic [DIM_W-1:0] grid_rows_r;
  logic [DIM_W-1:0] cols_eff;
  logic [DIM_W-1:0] rows_eff;
  logic             accept;

  logic             chain_vld [0:CELL_W];
  thn_div_t         chain_dat [0:CELL_W];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= 11'd1;
      grid_rows_r <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: grid_cols_r <= cfg_wdata;
        CFG_ROWS: grid_rows_r <= cfg_wdata;
        default:  grid_cols_r <= grid_cols_r;
      endcase
    end
  end

  // Zero acts as one; values above the limit act as the limit.
  always_comb begin
    if (grid_cols_r == '0) begin
      cols_eff = 11'd1;
    end else if ({{(LIMIT_W-DIM_W){1'b0}}, grid_cols_r} > MaxColsC) begin
      cols_eff = MaxColsC[DIM_W-1:0];
    end else begin
      cols_eff = grid_cols_r;
    end
    if (grid_rows_r == '0) begin
      rows_eff = 11'd1;
    end else if ({{(LIMIT_W-DIM_W){1'b0}}, grid_rows_r} > MaxRowsC) begin
      rows_eff = MaxRowsC[DIM_W-1:0];
    end else begin
      rows_eff = grid_rows_r;
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Front stages: cell number, local number, range check.
  thn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_act   (in_action),
    .in_he    (in_halfedge_in),
    .cols_eff (cols_eff),
    .rows_eff (rows_eff),
    .vld_o    (chain_vld[0]),
    .dat_o    (chain_dat[0])
  );

  // Divider chain: one row bit per cell, column left as remainder.
  for (genvar i = 0; i < CELL_W; i++) begin : g_cell
    thn_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (chain_vld[i]),
      .dat_i (chain_dat[i]),
      .vld_o (chain_vld[i+1]),
      .dat_o (chain_dat[i+1])
    );
  end

  // Back stages: neighbor step and result.
  thn_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (chain_vld[CELL_W]),
    .dat_i   (chain_dat[CELL_W]),
    .out_vld (out_valid),
    .out_idx (out_index_out),
    .out_bad (out_bad_index)
  );

  // Every result belongs to an item that was taken earlier.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching item");

  // An out-of-range item reports a zero index.
  a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_index_out == '0)
    else $error("flagged result carries a nonzero index");

endmodule
